### hw/rtl/assert_macros.svh
// assertion macros used by cdec_back
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every rising clock edge outside reset
`define CDEC_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("cdec assertion failed");
// expression must never be true outside reset
`define CDEC_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("cdec forbidden condition seen");
`else
`define CDEC_ASSERT(label, clk, rst, prop)
`define CDEC_NEVER(label, clk, rst, expr)
`endif
`endif

### hw/rtl/cdec_pkg.sv
package cdec_pkg;

   // default sizes
   localparam int MOTOR_COUNT_DEF   = 12;
   localparam int FRACTION_BITS_DEF = 16;
   localparam int QUEUE_DEPTH       = 2;

   // frame commands, identifier bits 10:4
   localparam logic [6:0] CMD_POSITION = 7'h0C;
   localparam logic [6:0] CMD_VELOCITY = 7'h0D;
   localparam logic [6:0] CMD_CURRENT  = 7'h0E;
   localparam logic [6:0] CMD_PACKED_A = 7'h09;
   localparam logic [6:0] CMD_PACKED_B = 7'h0A;
   localparam logic [6:0] CMD_PACKED_C = 7'h0B;
   localparam logic [3:0] PACKED_LENGTH = 4'd8;

   // item kinds, equal to the update kind reported
   localparam logic [2:0] KIND_NONE     = 3'd0;
   localparam logic [2:0] KIND_POSITION = 3'd1;
   localparam logic [2:0] KIND_VELOCITY = 3'd2;
   localparam logic [2:0] KIND_CURRENT  = 3'd3;
   localparam logic [2:0] KIND_ALL      = 3'd4;

   // register indexes
   localparam int CSR_INDEX_W = 3;
   localparam logic [2:0] REG_POSITION_RATIO = 3'd0;
   localparam logic [2:0] REG_VELOCITY_RATIO = 3'd1;
   localparam logic [2:0] REG_GEAR_RATIO     = 3'd2;
   localparam logic [2:0] REG_TORQUE_COEFF   = 3'd3;
   localparam logic [2:0] REG_ZERO_OFFSET    = 3'd4;
   localparam logic [2:0] REG_REVERSE_MASK   = 3'd5;
   localparam int REVERSE_W = 12;

   // constant divider
   localparam int DIV_W      = 48;
   localparam int DIV_STEP   = 8;
   localparam int DIV_CYC    = DIV_W / DIV_STEP;
   localparam int DIV_CNT_W  = $clog2(DIV_CYC + 1);
   localparam int REM_W      = 10;
   localparam logic [REM_W-1:0] DIVISOR_CURRENT  = 10'd1000;
   localparam logic [REM_W-1:0] DIVISOR_VELOCITY = 10'd10;

   typedef struct packed {
      logic        chan;
      logic [3:0]  idx;
      logic [2:0]  kind;
      logic [63:0] payload;
   } cdec_item_type;

   typedef struct packed {
      logic [31:0]          position_ratio;
      logic [31:0]          velocity_ratio;
      logic [31:0]          gear_ratio;
      logic [31:0]          torque_coeff;
      logic signed [31:0]   zero_offset;
      logic [REVERSE_W-1:0] reverse_mask;
   } cdec_cfg_type;

endpackage

### hw/rtl/cdec_front.sv
module cdec_front #(
   parameter int MOTOR_COUNT = cdec_pkg::MOTOR_COUNT_DEF
) (
   input  logic                   push,
   output logic                   full,
   input  logic                   bus_channel,
   input  logic [10:0]            frame_ident,
   input  logic [3:0]             frame_length,
   input  logic [63:0]            frame_payload,
   input  logic                   q_full,
   output logic                   q_push,
   output cdec_pkg::cdec_item_type q_item
);

   logic [3:0] nib;
   logic [6:0] cmd;
   logic       motor_ok;
   logic       packed_cmd;

   // motor select and command split
   assign nib        = frame_ident[3:0];
   assign cmd        = frame_ident[10:4];
   assign motor_ok   = (nib != 4'd0) && (nib <= 4'(MOTOR_COUNT));
   assign packed_cmd = (cmd == cdec_pkg::CMD_PACKED_A) || (cmd == cdec_pkg::CMD_PACKED_B) ||
                       (cmd == cdec_pkg::CMD_PACKED_C);

   // classify the frame
   always_comb begin
      q_item.chan    = bus_channel;
      q_item.idx     = nib - 4'd1;
      q_item.payload = frame_payload;
      if (cmd == cdec_pkg::CMD_POSITION) begin
         q_item.kind = cdec_pkg::KIND_POSITION;
      end else if (cmd == cdec_pkg::CMD_VELOCITY) begin
         q_item.kind = cdec_pkg::KIND_VELOCITY;
      end else if (cmd == cdec_pkg::CMD_CURRENT) begin
         q_item.kind = cdec_pkg::KIND_CURRENT;
      end else if (packed_cmd && (frame_length == cdec_pkg::PACKED_LENGTH)) begin
         q_item.kind = cdec_pkg::KIND_ALL;
      end else begin
         q_item.kind = cdec_pkg::KIND_NONE;
      end
   end

   // frames for unknown motors are taken and dropped
   assign full   = q_full;
   assign q_push = push && !q_full && motor_ok;

endmodule

### hw/rtl/cdec_queue.sv
module cdec_queue #(
   parameter int DEPTH = cdec_pkg::QUEUE_DEPTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    wr_en,
   input  cdec_pkg::cdec_item_type wr_item,
   output logic                    full,
   input  logic                    rd_en,
   output cdec_pkg::cdec_item_type rd_item,
   output logic                    empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   cdec_pkg::cdec_item_type mem_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0] count_ff;
   logic          do_wr, do_rd;

   assign full  = (count_ff == CW'(DEPTH));
   assign empty = (count_ff == '0);
   assign do_wr = wr_en && !full;
   assign do_rd = rd_en && !empty;
   assign rd_item = mem_ff[rd_ptr_ff];

   // storage
   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_item;
      end
   end

   // pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_wr) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
         end
         if (do_rd) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
         end
         if (do_wr && !do_rd) begin
            count_ff <= count_ff + CW'(1);
         end else if (do_rd && !do_wr) begin
            count_ff <= count_ff - CW'(1);
         end
      end
   end

endmodule

### hw/rtl/cdec_div.sv
module cdec_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [cdec_pkg::DIV_W-1:0]      dividend,
   input  logic [cdec_pkg::REM_W-1:0]      divisor,
   output logic                            done,
   output logic [cdec_pkg::DIV_W-1:0]      quotient
);

   localparam int W  = cdec_pkg::DIV_W;
   localparam int RW = cdec_pkg::REM_W;

   logic [W-1:0]                     dq_ff, dq_in;
   logic [RW-1:0]                    rem_ff, rem_in, d_ff;
   logic [cdec_pkg::DIV_CNT_W-1:0]   cnt_ff;
   logic                             run_ff, done_ff;

   // several restoring steps per cycle on a narrow remainder
   always_comb begin
      logic [RW:0] r;
      dq_in  = dq_ff;
      rem_in = rem_ff;
      r      = '0;
      for (int i = 0; i < cdec_pkg::DIV_STEP; i++) begin
         r     = {rem_in, dq_in[W-1]};
         dq_in = {dq_in[W-2:0], 1'b0};
         if (r >= {1'b0, d_ff}) begin
            r        = r - {1'b0, d_ff};
            dq_in[0] = 1'b1;
         end
         rem_in = r[RW-1:0];
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (start) begin
         dq_ff  <= dividend;
         rem_ff <= '0;
         d_ff   <= divisor;
      end else if (run_ff) begin
         dq_ff  <= dq_in;
         rem_ff <= rem_in;
      end
   end

   // step counter
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= cdec_pkg::DIV_CNT_W'(cdec_pkg::DIV_CYC);
         end else if (run_ff) begin
            cnt_ff <= cnt_ff - cdec_pkg::DIV_CNT_W'(1);
            if (cnt_ff == cdec_pkg::DIV_CNT_W'(1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = dq_ff;

endmodule

### hw/rtl/cdec_back.sv
`include "assert_macros.svh"

module cdec_back #(
   parameter int MOTOR_COUNT   = cdec_pkg::MOTOR_COUNT_DEF,
   parameter int FRACTION_BITS = cdec_pkg::FRACTION_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  cdec_pkg::cdec_cfg_type  cfg,
   input  logic                    q_empty,
   input  cdec_pkg::cdec_item_type q_item,
   output logic                    q_pop,
   output logic                    empty,
   input  logic                    pop,
   output logic [3:0]              motor_index,
   output logic [2:0]              update_kind,
   output logic signed [31:0]      position_value,
   output logic signed [31:0]      velocity_value,
   output logic signed [31:0]      current_value,
   output logic [31:0]             receive_count,
   output logic                    saturated
);

   localparam int IW = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;
   localparam logic [31:0] UNIT_RATIO = 32'd1 << FRACTION_BITS;
   localparam logic [63:0] G_HALF     = 64'd1 << (FRACTION_BITS - 1);
   localparam logic [56:0] HUGE_MAG   = 57'd1 << 40;

   // sequencer states
   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_FMUL   = 4'd1;
   localparam logic [3:0] S_FSHIFT = 4'd2;
   localparam logic [3:0] S_FOFS   = 4'd3;
   localparam logic [3:0] S_GMUL   = 4'd4;
   localparam logic [3:0] S_GRND   = 4'd5;
   localparam logic [3:0] S_CM0    = 4'd6;
   localparam logic [3:0] S_CM1    = 4'd7;
   localparam logic [3:0] S_CSUM   = 4'd8;
   localparam logic [3:0] S_DIV    = 4'd9;
   localparam logic [3:0] S_CFIN   = 4'd10;
   localparam logic [3:0] S_VMUL   = 4'd11;
   localparam logic [3:0] S_VSUM   = 4'd12;
   localparam logic [3:0] S_VFIN   = 4'd13;
   localparam logic [3:0] S_OUT    = 4'd14;

   // float destinations
   localparam logic [1:0] FM_POS  = 2'd0;
   localparam logic [1:0] FM_VEL  = 2'd1;
   localparam logic [1:0] FM_CUR  = 2'd2;
   localparam logic [1:0] FM_PPOS = 2'd3;

   // magnitude to signed 32 with clipping, result is {sat, value}
   function automatic logic [32:0] from_mag(input logic [56:0] mag, input logic neg);
      logic [32:0] res;
      if (neg) begin
         if (mag > 57'h80000000) begin
            res = {1'b1, 32'h80000000};
         end else begin
            res = {1'b0, (~mag[31:0]) + 32'd1};
         end
      end else begin
         if (mag > 57'h7FFFFFFF) begin
            res = {1'b1, 32'h7FFFFFFF};
         end else begin
            res = {1'b0, mag[31:0]};
         end
      end
      return res;
   endfunction

   logic [3:0]         state_ff, state_in;
   logic [3:0]         idx_ff;
   logic [2:0]         kind_ff;
   logic [63:0]        pay_ff;
   logic               flip_ff, fflip_ff, sat_ff, huge_ff, div_vel_ff;
   logic [31:0]        fbits_ff, fratio_ff;
   logic [1:0]         fmode_ff;
   logic [63:0]        prod_ff, g_ff;
   logic [47:0]        acc_ff;
   logic signed [31:0] v_ff;

   logic signed [31:0] pos_tab_ff [MOTOR_COUNT];
   logic signed [31:0] vel_tab_ff [MOTOR_COUNT];
   logic signed [31:0] cur_tab_ff [MOTOR_COUNT];
   logic [31:0]        cnt_tab_ff [MOTOR_COUNT];
   logic               chan_tab_ff [MOTOR_COUNT];

   logic               out_valid_ff;
   logic [3:0]         rsp_idx_ff;
   logic [2:0]         rsp_kind_ff;
   logic signed [31:0] rsp_pos_ff, rsp_vel_ff, rsp_cur_ff;
   logic [31:0]        rsp_cnt_ff;
   logic               rsp_sat_ff;

   logic [IW-1:0] iidx, ti;
   logic [15:0]   rev16;
   logic          in_flip;
   logic [15:0]   m0, m1;
   logic          n0, n1;
   logic [31:0]   mul_a, mul_b;
   logic          out_load;

   assign iidx    = q_item.idx[IW-1:0];
   assign ti      = idx_ff[IW-1:0];
   assign rev16   = {4'd0, cfg.reverse_mask};
   assign in_flip = rev16[q_item.idx];
   assign q_pop   = (state_ff == S_IDLE) && !q_empty;
   assign out_load = (state_ff == S_OUT) && (!out_valid_ff || pop);

   // packed int16 magnitudes and signs
   assign n0 = pay_ff[15];
   assign n1 = pay_ff[31];
   assign m0 = n0 ? (16'd0 - pay_ff[15:0]) : pay_ff[15:0];
   assign m1 = n1 ? (16'd0 - pay_ff[31:16]) : pay_ff[31:16];

   // shared multiplier operands
   always_comb begin
      case (state_ff)
         S_FMUL: begin
            mul_a = {8'd0, (fbits_ff[30:23] != 8'd0), fbits_ff[22:0]};
            mul_b = fratio_ff;
         end
         S_GMUL: begin
            mul_a = cfg.torque_coeff;
            mul_b = cfg.gear_ratio;
         end
         S_CM0: begin
            mul_a = {16'd0, m0};
            mul_b = g_ff[31:0];
         end
         S_CM1: begin
            mul_a = {16'd0, m0};
            mul_b = {16'd0, g_ff[47:32]};
         end
         S_VMUL: begin
            mul_a = {16'd0, m1};
            mul_b = cfg.velocity_ratio;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // float times ratio: exponent shift, rounding and clipping
   logic [32:0] fres;
   always_comb begin
      logic [7:0]         fe;
      logic signed [9:0]  fx;
      logic signed [9:0]  nsh;
      logic [5:0]         fsh;
      logic [55:0]        fp;
      logic [56:0]        fbound;
      logic [63:0]        fl;
      logic [57:0]        fr;
      logic [57:0]        frs;
      logic [56:0]        fmag;
      logic               fnan;
      fe     = fbits_ff[30:23];
      fp     = prod_ff[55:0];
      fx     = (fe == 8'd0) ? -10'sd149 : ($signed({2'b00, fe}) - 10'sd150);
      nsh    = -fx;
      fsh    = '0;
      fbound = '0;
      fl     = '0;
      fr     = '0;
      frs    = '0;
      fmag   = '0;
      fnan   = 1'b0;
      if (fe == 8'hFF) begin
         fnan = (fbits_ff[22:0] != 23'd0);
         fmag = HUGE_MAG;
      end else if (!fx[9]) begin
         // a zero product stays zero however large the exponent
         if (fx >= 10'sd33) begin
            fmag = (fp == 56'd0) ? 57'd0 : HUGE_MAG;
         end else begin
            fsh    = fx[5:0];
            fbound = 57'd1 << (6'd33 - fsh);
            if ({1'b0, fp} > fbound) begin
               fmag = HUGE_MAG;
            end else begin
               fl   = {8'd0, fp} << fsh;
               fmag = {16'd0, fl[40:0]};
            end
         end
      end else if (nsh < 10'sd62) begin
         fsh  = nsh[5:0];
         fr   = {2'b00, fp} + (58'd1 << (fsh - 6'd1));
         frs  = fr >> fsh;
         fmag = frs[56:0];
      end
      if (fnan) begin
         fres = {1'b1, 32'd0};
      end else begin
         fres = from_mag(fmag, fbits_ff[31] ^ fflip_ff);
      end
   end

   // zero offset and clip of the position
   logic [32:0] ofs_res;
   always_comb begin
      logic signed [33:0] ofs_sum;
      if (fmode_ff == FM_PPOS) begin
         ofs_sum = 34'(v_ff) + 34'(cfg.zero_offset);
      end else begin
         ofs_sum = 34'(v_ff) - 34'(cfg.zero_offset);
      end
      if (ofs_sum > 34'sd2147483647) begin
         ofs_res = {1'b1, 32'h7FFFFFFF};
      end else if (ofs_sum < -34'sd2147483648) begin
         ofs_res = {1'b1, 32'h80000000};
      end else begin
         ofs_res = {1'b0, ofs_sum[31:0]};
      end
   end

   // packed current sum before division
   logic [63:0] cur_x;
   logic        cur_huge;
   logic [47:0] vel_x;
   assign cur_x    = {prod_ff[31:0], 32'd0} + {16'd0, acc_ff} + 64'd500;
   assign cur_huge = (cur_x[63:48] != 16'd0) || ((g_ff[63:48] != 16'd0) && (m0 != 16'd0));
   assign vel_x    = prod_ff[47:0] + 48'd5;

   // constant divider
   logic                        div_start, div_done;
   logic [cdec_pkg::DIV_W-1:0]  div_quot;
   assign div_start = (state_ff == S_CSUM) || (state_ff == S_VSUM);

   cdec_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ((state_ff == S_CSUM) ? cur_x[47:0] : vel_x),
      .divisor  ((state_ff == S_CSUM) ? cdec_pkg::DIVISOR_CURRENT
                                      : cdec_pkg::DIVISOR_VELOCITY),
      .done     (div_done),
      .quotient (div_quot)
   );

   logic [32:0] cfin_res, vfin_res;
   assign cfin_res = from_mag(huge_ff ? HUGE_MAG : {9'd0, div_quot}, n0 ^ flip_ff);
   assign vfin_res = from_mag({9'd0, div_quot}, n1 ^ flip_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (!q_empty) begin
               if ((q_item.kind == cdec_pkg::KIND_POSITION) ||
                   (q_item.kind == cdec_pkg::KIND_VELOCITY) ||
                   (q_item.kind == cdec_pkg::KIND_CURRENT)) begin
                  state_in = S_FMUL;
               end else if (q_item.kind == cdec_pkg::KIND_ALL) begin
                  state_in = S_GMUL;
               end else begin
                  state_in = S_OUT;
               end
            end
         end
         S_FMUL:   state_in = S_FSHIFT;
         S_FSHIFT: state_in = S_FOFS;
         S_FOFS:   state_in = S_OUT;
         S_GMUL:   state_in = S_GRND;
         S_GRND:   state_in = S_CM0;
         S_CM0:    state_in = S_CM1;
         S_CM1:    state_in = S_CSUM;
         S_CSUM:   state_in = S_DIV;
         S_DIV: begin
            if (div_done) begin
               state_in = div_vel_ff ? S_VFIN : S_CFIN;
            end
         end
         S_CFIN:   state_in = S_VMUL;
         S_VMUL:   state_in = S_VSUM;
         S_VSUM:   state_in = S_DIV;
         S_VFIN:   state_in = S_FMUL;
         S_OUT: begin
            if (!out_valid_ff || pop) begin
               state_in = S_IDLE;
            end
         end
         default:  state_in = S_IDLE;
      endcase
   end

   // working registers
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      case (state_ff)
         S_IDLE: begin
            if (!q_empty) begin
               idx_ff   <= q_item.idx;
               kind_ff  <= q_item.kind;
               pay_ff   <= q_item.payload;
               flip_ff  <= in_flip;
               sat_ff   <= 1'b0;
               fbits_ff <= q_item.payload[31:0];
               fflip_ff <= 1'b0;
               case (q_item.kind)
                  cdec_pkg::KIND_VELOCITY: begin
                     fratio_ff <= UNIT_RATIO;
                     fmode_ff  <= FM_VEL;
                  end
                  cdec_pkg::KIND_CURRENT: begin
                     fratio_ff <= cfg.torque_coeff;
                     fmode_ff  <= FM_CUR;
                  end
                  default: begin
                     fratio_ff <= cfg.position_ratio;
                     fmode_ff  <= FM_POS;
                  end
               endcase
            end
         end
         S_FSHIFT: begin
            v_ff   <= fres[31:0];
            sat_ff <= sat_ff | fres[32];
         end
         S_FOFS: begin
            if ((fmode_ff == FM_POS) || (fmode_ff == FM_PPOS)) begin
               sat_ff <= sat_ff | ofs_res[32];
            end
         end
         S_GRND: begin
            g_ff <= (prod_ff + G_HALF) >> FRACTION_BITS;
         end
         S_CM1: begin
            acc_ff <= prod_ff[47:0];
         end
         S_CSUM: begin
            huge_ff    <= cur_huge;
            div_vel_ff <= 1'b0;
         end
         S_CFIN: begin
            sat_ff <= sat_ff | cfin_res[32];
         end
         S_VSUM: begin
            huge_ff    <= 1'b0;
            div_vel_ff <= 1'b1;
         end
         S_VFIN: begin
            sat_ff    <= sat_ff | vfin_res[32];
            fbits_ff  <= pay_ff[63:32];
            fratio_ff <= cfg.position_ratio;
            fflip_ff  <= flip_ff;
            fmode_ff  <= FM_PPOS;
         end
         default: begin
         end
      endcase
   end

   // per motor state and sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         for (int i = 0; i < MOTOR_COUNT; i++) begin
            pos_tab_ff[i]  <= '0;
            vel_tab_ff[i]  <= '0;
            cur_tab_ff[i]  <= '0;
            cnt_tab_ff[i]  <= '0;
            chan_tab_ff[i] <= 1'b0;
         end
      end else begin
         state_ff <= state_in;
         case (state_ff)
            S_IDLE: begin
               if (!q_empty) begin
                  chan_tab_ff[iidx] <= q_item.chan;
                  cnt_tab_ff[iidx]  <= cnt_tab_ff[iidx] + 32'd1;
               end
            end
            S_FOFS: begin
               case (fmode_ff)
                  FM_VEL:  vel_tab_ff[ti] <= v_ff;
                  FM_CUR:  cur_tab_ff[ti] <= v_ff;
                  default: pos_tab_ff[ti] <= ofs_res[31:0];
               endcase
            end
            S_CFIN: cur_tab_ff[ti] <= cfin_res[31:0];
            S_VFIN: vel_tab_ff[ti] <= vfin_res[31:0];
            default: begin
            end
         endcase
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_load) begin
         out_valid_ff <= 1'b1;
      end else if (pop) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_idx_ff  <= idx_ff;
         rsp_kind_ff <= kind_ff;
         rsp_pos_ff  <= pos_tab_ff[ti];
         rsp_vel_ff  <= vel_tab_ff[ti];
         rsp_cur_ff  <= cur_tab_ff[ti];
         rsp_cnt_ff  <= cnt_tab_ff[ti];
         rsp_sat_ff  <= sat_ff;
      end
   end

   assign empty          = !out_valid_ff;
   assign motor_index    = rsp_idx_ff;
   assign update_kind    = rsp_kind_ff;
   assign position_value = rsp_pos_ff;
   assign velocity_value = rsp_vel_ff;
   assign current_value  = rsp_cur_ff;
   assign receive_count  = rsp_cnt_ff;
   assign saturated      = rsp_sat_ff;

   // divider finishes only while the sequencer waits for it
   `CDEC_ASSERT(a_div_done_waits, clock, reset, div_done |-> state_ff == S_DIV)
   // current finish only follows the current division
   `CDEC_NEVER(a_cfin_after_vel, clock, reset, (state_ff == S_CFIN) && div_vel_ff)
   // float multiply entered only from a fresh item or the packed velocity step
   `CDEC_ASSERT(a_fmul_entry, clock, reset,
      (state_ff == S_FMUL) |-> ($past(state_ff) == S_IDLE || $past(state_ff) == S_VFIN))

endmodule

### hw/rtl/can_motor_feedback_decoder_top.sv
// CAN motor feedback decoder. Frames go in through a push/full queue port and
// per motor results come out of a pop/empty port. A frame whose identifier
// nibble is not a motor (0 or above MOTOR_COUNT) is taken and dropped with no
// result. Accepted frames are classified and held in a two entry queue; the
// back end then handles one frame at a time with one shared 32x32 multiplier
// and an eight bit per cycle divider by 1000 or 10. A frame with no value
// goes straight to the result step, a single float command through multiply,
// shift and offset steps, and a packed frame through the gear, current and
// velocity multiplies, the two divisions it waits on, and the float steps.
// Registers are written over the csr port, which is always ready. The user
// must write only while the block is idle, which the block does not enforce.
module can_motor_feedback_decoder_top #(
   parameter int MOTOR_COUNT   = cdec_pkg::MOTOR_COUNT_DEF,
   parameter int FRACTION_BITS = cdec_pkg::FRACTION_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               push,
   output logic                               full,
   input  logic                               req_bus_channel,
   input  logic [10:0]                        req_frame_ident,
   input  logic [3:0]                         req_frame_length,
   input  logic [63:0]                        req_frame_payload,
   output logic                               empty,
   input  logic                               pop,
   output logic [3:0]                         rsp_motor_index,
   output logic [2:0]                         rsp_update_kind,
   output logic signed [31:0]                 rsp_position_value,
   output logic signed [31:0]                 rsp_velocity_value,
   output logic signed [31:0]                 rsp_current_value,
   output logic [31:0]                        rsp_receive_count,
   output logic                               rsp_saturated,
   input  logic                               valid,
   output logic                               ready,
   input  logic [cdec_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [31:0]                        csr_data
);

   cdec_pkg::cdec_cfg_type  cfg_ff;
   cdec_pkg::cdec_item_type f_item, q_item;
   logic                    q_full, q_push, q_empty, q_pop;

   // configuration registers
   assign ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.position_ratio <= 32'd1 << FRACTION_BITS;
         cfg_ff.velocity_ratio <= 32'd1 << FRACTION_BITS;
         cfg_ff.gear_ratio     <= 32'd1 << FRACTION_BITS;
         cfg_ff.torque_coeff   <= 32'd1 << FRACTION_BITS;
         cfg_ff.zero_offset    <= '0;
         cfg_ff.reverse_mask   <= '0;
      end else if (valid && ready) begin
         case (csr_index)
            cdec_pkg::REG_POSITION_RATIO: cfg_ff.position_ratio <= csr_data;
            cdec_pkg::REG_VELOCITY_RATIO: cfg_ff.velocity_ratio <= csr_data;
            cdec_pkg::REG_GEAR_RATIO:     cfg_ff.gear_ratio     <= csr_data;
            cdec_pkg::REG_TORQUE_COEFF:   cfg_ff.torque_coeff   <= csr_data;
            cdec_pkg::REG_ZERO_OFFSET:    cfg_ff.zero_offset    <= csr_data;
            cdec_pkg::REG_REVERSE_MASK:
               cfg_ff.reverse_mask <= csr_data[cdec_pkg::REVERSE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // front: accept and classify
   cdec_front #(
      .MOTOR_COUNT (MOTOR_COUNT)
   ) u_front (
      .push          (push),
      .full          (full),
      .bus_channel   (req_bus_channel),
      .frame_ident   (req_frame_ident),
      .frame_length  (req_frame_length),
      .frame_payload (req_frame_payload),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_item        (f_item)
   );

   // queue between front and back
   cdec_queue #(
      .DEPTH (cdec_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (q_push),
      .wr_item (f_item),
      .full    (q_full),
      .rd_en   (q_pop),
      .rd_item (q_item),
      .empty   (q_empty)
   );

   // back: arithmetic, motor state and result register
   cdec_back #(
      .MOTOR_COUNT   (MOTOR_COUNT),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .q_empty        (q_empty),
      .q_item         (q_item),
      .q_pop          (q_pop),
      .empty          (empty),
      .pop            (pop),
      .motor_index    (rsp_motor_index),
      .update_kind    (rsp_update_kind),
      .position_value (rsp_position_value),
      .velocity_value (rsp_velocity_value),
      .current_value  (rsp_current_value),
      .receive_count  (rsp_receive_count),
      .saturated      (rsp_saturated)
   );

endmodule

### verif/can_motor_feedback_decoder_checker.sv
module can_motor_feedback_decoder_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  logic               full,
   input  logic               req_bus_channel,
   input  logic [10:0]        req_frame_ident,
   input  logic [3:0]         req_frame_length,
   input  logic [63:0]        req_frame_payload,
   input  logic               empty,
   input  logic               pop,
   input  logic [3:0]         rsp_motor_index,
   input  logic [2:0]         rsp_update_kind,
   input  logic signed [31:0] rsp_position_value,
   input  logic signed [31:0] rsp_velocity_value,
   input  logic signed [31:0] rsp_current_value,
   input  logic [31:0]        rsp_receive_count,
   input  logic               rsp_saturated,
   input  logic               valid,
   input  logic               ready,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_data,
   output int                 fail_count,
   output int                 pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MOTORS = cdec_pkg::MOTOR_COUNT_DEF;
   localparam int FRAC = cdec_pkg::FRACTION_BITS_DEF;
   localparam longint unsigned HUGE_MAG = 64'd1 << 40;

   typedef struct {
      logic [3:0]  motor;
      logic [2:0]  kind;
      logic [31:0] pos;
      logic [31:0] vel;
      logic [31:0] cur;
      logic [31:0] count;
      logic        sat;
   } feedback_type;

   feedback_type feedback_q[$];

   // shadow registers and per motor tables
   logic [31:0] position_scale, velocity_scale, gear, torque, zero_ofs;
   logic [11:0] rev_mask;
   logic [31:0] pos_tab[MOTORS];
   logic [31:0] vel_tab[MOTORS];
   logic [31:0] cur_tab[MOTORS];
   logic [31:0] cnt_tab[MOTORS];
   logic        chan_tab[MOTORS];

   // signed value from magnitude and sign, clipped to 32 bits
   function automatic longint signed_from_mag(longint unsigned mag, bit neg, inout bit sat);
      if (neg) begin
         if (mag > 64'h80000000) begin
            sat = 1;
            return -64'sd2147483648;
         end
         return -longint'(mag);
      end
      if (mag > 64'h7FFFFFFF) begin
         sat = 1;
         return 64'sd2147483647;
      end
      return longint'(mag);
   endfunction

   function automatic longint clip_word(longint v, inout bit sat);
      if (v > 64'sd2147483647) begin
         sat = 1;
         return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
         sat = 1;
         return -64'sd2147483648;
      end
      return v;
   endfunction

   // ieee single times an unsigned fixed point factor, rounded half away
   function automatic longint float_to_fixed(logic [31:0] bits, longint unsigned ratio,
                                             bit flip, inout bit sat);
      bit neg;
      int ex;
      int sh;
      longint unsigned m, p, mag;
      neg = bits[31] ^ flip;
      m = bits[22:0];
      if (bits[30:23] == 8'hFF) begin
         if (m != 0) begin
            sat = 1;
            return 0;
         end
         return signed_from_mag(HUGE_MAG, neg, sat);
      end
      if (bits[30:23] == 8'h00) begin
         ex = -149;
      end else begin
         m = m | (64'd1 << 23);
         ex = int'(bits[30:23]) - 150;
      end
      p = m * ratio;
      if (p == 0) return 0;
      if (ex >= 0) begin
         if (ex >= 33 || p > (64'd1 << (33 - ex))) mag = HUGE_MAG;
         else mag = p << ex;
      end else begin
         sh = -ex;
         if (sh >= 62) mag = 0;
         else mag = (p + (64'd1 << (sh - 1))) >> sh;
      end
      return signed_from_mag(mag, neg, sat);
   endfunction

   // update the motor tables for one frame, tell whether a result follows
   function automatic bit decode_frame(logic chan, logic [10:0] ident, logic [3:0] len,
                                       logic [63:0] pay, output feedback_type fb);
      logic [6:0] cmd;
      int idx;
      bit sat, flip, n0, n1;
      logic [2:0] kind;
      longint zero, v;
      longint unsigned m0, m1, g, mag;
      logic [15:0] raw0, raw1;
      cmd = ident[10:4];
      fb = '{default: '0};
      if (ident[3:0] == 0 || ident[3:0] > MOTORS) return 0;
      idx = ident[3:0] - 1;
      sat = 0;
      kind = cdec_pkg::KIND_NONE;
      zero = longint'(signed'(zero_ofs));
      chan_tab[idx] = chan;
      cnt_tab[idx] = cnt_tab[idx] + 32'd1;
      if (cmd == cdec_pkg::CMD_POSITION) begin
         v = float_to_fixed(pay[31:0], position_scale, 1'b0, sat);
         pos_tab[idx] = 32'(clip_word(v - zero, sat));
         kind = cdec_pkg::KIND_POSITION;
      end else if (cmd == cdec_pkg::CMD_VELOCITY) begin
         vel_tab[idx] = 32'(float_to_fixed(pay[31:0], 64'd1 << FRAC, 1'b0, sat));
         kind = cdec_pkg::KIND_VELOCITY;
      end else if (cmd == cdec_pkg::CMD_CURRENT) begin
         cur_tab[idx] = 32'(float_to_fixed(pay[31:0], torque, 1'b0, sat));
         kind = cdec_pkg::KIND_CURRENT;
      end else if ((cmd == cdec_pkg::CMD_PACKED_A || cmd == cdec_pkg::CMD_PACKED_B ||
                    cmd == cdec_pkg::CMD_PACKED_C) && len == cdec_pkg::PACKED_LENGTH) begin
         flip = (idx < 12) ? rev_mask[idx] : 1'b0;
         raw0 = pay[15:0];
         raw1 = pay[31:16];
         n0 = raw0[15];
         n1 = raw1[15];
         m0 = n0 ? (64'h10000 - raw0) : 64'(raw0);
         m1 = n1 ? (64'h10000 - raw1) : 64'(raw1);
         g = ((longint'(torque) * longint'(gear)) + (64'd1 << (FRAC - 1))) >> FRAC;
         if (m0 != 0 && g >= (64'd1 << 48)) mag = HUGE_MAG;
         else mag = (m0 * g + 500) / 1000;
         cur_tab[idx] = 32'(signed_from_mag(mag, n0 != flip, sat));
         mag = (m1 * longint'(velocity_scale) + 5) / 10;
         vel_tab[idx] = 32'(signed_from_mag(mag, n1 != flip, sat));
         v = float_to_fixed(pay[63:32], position_scale, flip, sat);
         pos_tab[idx] = 32'(clip_word(v + zero, sat));
         kind = cdec_pkg::KIND_ALL;
      end
      fb.motor = 4'(idx);
      fb.kind = kind;
      fb.pos = pos_tab[idx];
      fb.vel = vel_tab[idx];
      fb.cur = cur_tab[idx];
      fb.count = cnt_tab[idx];
      fb.sat = sat;
      return 1;
   endfunction

   always @(posedge clock) begin
      feedback_type fb, want;
      if (reset) begin
         position_scale = 32'd1 << FRAC;
         velocity_scale = 32'd1 << FRAC;
         gear = 32'd1 << FRAC;
         torque = 32'd1 << FRAC;
         zero_ofs = 0;
         rev_mask = 0;
         for (int i = 0; i < MOTORS; i++) begin
            pos_tab[i] = 0;
            vel_tab[i] = 0;
            cur_tab[i] = 0;
            cnt_tab[i] = 0;
            chan_tab[i] = 0;
         end
         feedback_q.delete();
      end else begin
         // register writes
         if (valid && ready) begin
            case (csr_index)
               cdec_pkg::REG_POSITION_RATIO: position_scale = csr_data;
               cdec_pkg::REG_VELOCITY_RATIO: velocity_scale = csr_data;
               cdec_pkg::REG_GEAR_RATIO: gear = csr_data;
               cdec_pkg::REG_TORQUE_COEFF: torque = csr_data;
               cdec_pkg::REG_ZERO_OFFSET: zero_ofs = csr_data;
               cdec_pkg::REG_REVERSE_MASK: rev_mask = csr_data[11:0];
               default: ;
            endcase
         end
         // accepted result item against oldest expectation
         if (pop && !empty) begin
            if (feedback_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected result item: motor %0d kind %0d",
                           rsp_motor_index, rsp_update_kind);
            end else begin
               want = feedback_q.pop_front();
               if (rsp_motor_index !== want.motor || rsp_update_kind !== want.kind ||
                   rsp_position_value !== want.pos || rsp_velocity_value !== want.vel ||
                   rsp_current_value !== want.cur || rsp_receive_count !== want.count ||
                   rsp_saturated !== want.sat) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display({"mismatch: exp m%0d k%0d p%h v%h c%h n%h s%b",
                               " got m%0d k%0d p%h v%h c%h n%h s%b"},
                              want.motor, want.kind, want.pos, want.vel, want.cur,
                              want.count, want.sat, rsp_motor_index, rsp_update_kind,
                              rsp_position_value, rsp_velocity_value, rsp_current_value,
                              rsp_receive_count, rsp_saturated);
               end
            end
         end
         // accepted frame item
         if (push && !full) begin
            if (decode_frame(req_bus_channel, req_frame_ident, req_frame_length,
                             req_frame_payload, fb))
               feedback_q.push_back(fb);
         end
      end
      pending = feedback_q.size();
   end

   initial begin
      fail_count = 0;
      pending = 0;
   end
endmodule

### verif/tb_can_motor_feedback_decoder_top.sv
module tb_can_motor_feedback_decoder_top;
   timeunit 1ns;
   timeprecision 1ps;

   logic clock = 0;
   logic reset;
   logic push, full, empty, pop, valid, ready;
   logic req_bus_channel;
   logic [10:0] req_frame_ident;
   logic [3:0] req_frame_length;
   logic [63:0] req_frame_payload;
   logic [3:0] rsp_motor_index;
   logic [2:0] rsp_update_kind;
   logic signed [31:0] rsp_position_value, rsp_velocity_value, rsp_current_value;
   logic [31:0] rsp_receive_count;
   logic rsp_saturated;
   logic [2:0] csr_index;
   logic [31:0] csr_data;
   int fail_count, pending;
   bit hold_req = 0;

   can_motor_feedback_decoder_top uut (.*);
   can_motor_feedback_decoder_checker checker_inst (.*);

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   initial begin
      #20ms;
      $display("Test completed with failures");
      $finish;
   end

   // result side with random stalls and one long hold-off
   initial begin
      int n;
      pop <= 0;
      do @(posedge clock); while (reset);
      forever begin
         pop <= 1;
         do @(posedge clock); while (empty);
         n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
         if (hold_req) begin
            hold_req = 0;
            n = 400;
         end
         if (n > 0) begin
            pop <= 0;
            repeat (n) @(posedge clock);
         end
      end
   end

   task automatic send_frame(logic chan, logic [10:0] ident, logic [3:0] len,
                             logic [63:0] pay);
      int n;
      n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
      if (n > 0) begin
         push <= 0;
         repeat (n) @(posedge clock);
      end
      req_bus_channel <= chan;
      req_frame_ident <= ident;
      req_frame_length <= len;
      req_frame_payload <= pay;
      push <= 1;
      do @(posedge clock); while (full);
   endtask

   // wait so that the last accepted frame is counted as pending
   task automatic drain();
      push <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (64) @(posedge clock);
   endtask

   task automatic write_regs(logic [31:0] pr, logic [31:0] vr, logic [31:0] gr,
                             logic [31:0] tc, logic [31:0] zo, logic [31:0] rm);
      logic [31:0] vals[6];
      vals = '{pr, vr, gr, tc, zo, rm};
      valid <= 1;
      for (int i = 0; i < 6; i++) begin
         csr_index <= i[2:0];
         csr_data <= vals[i];
         do @(posedge clock); while (!ready);
      end
      valid <= 0;
   endtask

   function automatic logic [31:0] rand_float();
      case ($urandom_range(0, 9))
         0: return $urandom;
         1: return {1'($urandom), 8'hFF, ($urandom_range(0, 1) ? 23'($urandom) : 23'd0)};
         2: return {1'($urandom), 8'h00, 23'($urandom)};
         3: return {1'($urandom), 31'd0};
         default: return {1'($urandom), 8'($urandom_range(100, 160)), 23'($urandom)};
      endcase
   endfunction

   function automatic logic [15:0] rand_int16();
      case ($urandom_range(0, 7))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'($urandom_range(0, 40)) ^ {16{1'($urandom)}};
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_random();
      logic [6:0] cmd;
      logic [3:0] nib, len;
      logic [31:0] lo, hi;
      logic [6:0] cmds[6];
      cmds = '{cdec_pkg::CMD_POSITION, cdec_pkg::CMD_VELOCITY, cdec_pkg::CMD_CURRENT,
               cdec_pkg::CMD_PACKED_A, cdec_pkg::CMD_PACKED_B, cdec_pkg::CMD_PACKED_C};
      nib = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(1, 12));
      cmd = ($urandom_range(0, 6) == 0) ? 7'($urandom) : cmds[$urandom_range(0, 5)];
      len = ($urandom_range(0, 5) == 0) ? 4'($urandom_range(0, 8))
                                         : cdec_pkg::PACKED_LENGTH;
      if (cmd == cdec_pkg::CMD_PACKED_A || cmd == cdec_pkg::CMD_PACKED_B ||
          cmd == cdec_pkg::CMD_PACKED_C) begin
         lo = {rand_int16(), rand_int16()};
         hi = rand_float();
      end else begin
         lo = rand_float();
         hi = $urandom;
      end
      send_frame(1'($urandom), {cmd, nib}, len, {hi, lo});
   endtask

   function automatic logic [31:0] rand_ratio();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return 32'd0;
         default: return $urandom_range(0, 32'h40000);
      endcase
   endfunction

   initial begin
      reset <= 1;
      push <= 0;
      valid <= 0;
      csr_index <= 0;
      csr_data <= 0;
      req_bus_channel <= 0;
      req_frame_ident <= 0;
      req_frame_length <= 0;
      req_frame_payload <= 0;
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed frames at reset settings
      send_frame(1'b0, {cdec_pkg::CMD_POSITION, 4'd1}, 4'd4, 64'h3F800000);
      send_frame(1'b1, {cdec_pkg::CMD_POSITION, 4'd12}, 4'd0, 64'hFFFFFFFF_7FC00000);
      send_frame(1'b0, {cdec_pkg::CMD_VELOCITY, 4'd2}, 4'd8, 64'h7F800000);
      send_frame(1'b1, {cdec_pkg::CMD_CURRENT, 4'd3}, 4'd8, 64'hFF800000);
      send_frame(1'b0, {cdec_pkg::CMD_POSITION, 4'd4}, 4'd8, 64'h00000001);
      send_frame(1'b0, {cdec_pkg::CMD_VELOCITY, 4'd5}, 4'd8, 64'h80000000);
      send_frame(1'b1, {cdec_pkg::CMD_CURRENT, 4'd6}, 4'd8, 64'hC2F60000);
      send_frame(1'b0, {cdec_pkg::CMD_POSITION, 4'd7}, 4'd8, 64'h4F000000);
      send_frame(1'b1, {cdec_pkg::CMD_PACKED_A, 4'd8}, 4'd8, 64'h3F800000_7FFF8000);
      send_frame(1'b0, {cdec_pkg::CMD_PACKED_B, 4'd9}, 4'd8, 64'hBF800000_80007FFF);
      send_frame(1'b1, {cdec_pkg::CMD_PACKED_C, 4'd10}, 4'd8, 64'hFFFFFFFF_FFFFFFFF);
      send_frame(1'b0, {cdec_pkg::CMD_PACKED_A, 4'd11}, 4'd7, 64'h3F800000_00010001);
      send_frame(1'b1, {7'h7F, 4'd12}, 4'd8, 64'h0);
      send_frame(1'b0, {cdec_pkg::CMD_POSITION, 4'd0}, 4'd8, 64'h3F800000);
      send_frame(1'b1, {cdec_pkg::CMD_POSITION, 4'd13}, 4'd8, 64'h3F800000);
      send_frame(1'b0, {cdec_pkg::CMD_VELOCITY, 4'd15}, 4'd8, 64'h3F800000);
      send_frame(1'b1, {7'h00, 4'd1}, 4'd0, 64'h0);
      send_frame(1'b0, {cdec_pkg::CMD_PACKED_C, 4'd12}, 4'd8, 64'h7F800001_00000000);
      drain();

      // reversed motors and extreme offsets
      write_regs(32'h10000, 32'h10000, 32'h10000, 32'h10000, 32'h80000000, 32'hFFF);
      send_frame(1'b0, {cdec_pkg::CMD_PACKED_A, 4'd1}, 4'd8, 64'h3F800000_7FFF8000);
      send_frame(1'b1, {cdec_pkg::CMD_POSITION, 4'd2}, 4'd8, 64'h3F800000);
      drain();

      // a huge float against zero ratios
      write_regs(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
      send_frame(1'b0, {cdec_pkg::CMD_POSITION, 4'd3}, 4'd8, 64'h7F000000);
      send_frame(1'b1, {cdec_pkg::CMD_PACKED_B, 4'd4}, 4'd8, 64'h7F000000_00010001);
      drain();

      for (int ph = 0; ph < 9; ph++) begin
         case (ph)
            0: write_regs('1, '1, '1, '1, 32'h7FFFFFFF, 32'hFFF);
            1: write_regs(32'd0, 32'd0, 32'd0, 32'd0, 32'h80000000, 32'd0);
            2: write_regs(32'h10000, 32'h10000, 32'h10000, 32'h10000, 32'd0, 32'd0);
            default: write_regs(rand_ratio(), rand_ratio(), rand_ratio(), rand_ratio(),
                                ($urandom_range(0, 3) == 0) ? $urandom
                                                            : $urandom_range(0, 32'h80000)
                                                              - 32'h40000,
                                $urandom_range(0, 4095));
         endcase
         if (ph == 3) hold_req = 1;
         repeat (200) send_random();
         drain();
      end

      if (fail_count == 0 && pending == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule
